>>> src/charge_line_monitor_defines.svh
// Assertion macros for the charge line monitor.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CHARGE_LINE_MONITOR_DEFINES_SVH
`define CHARGE_LINE_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// When ante holds, cons holds in the same cycle.
`define CLM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("charge line monitor: implication check failed");

// When ante holds, cons holds in the next cycle.
`define CLM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("charge line monitor: next-cycle check failed");

`else

`define CLM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/clm_pkg.sv
// Shared types and constants for the charge line monitor.
// Used by every module of the block; depends on nothing.
package clm_pkg;

   // Command codes.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_ENABLE  = 2'd1;
   localparam logic [1:0] CMD_DISABLE = 2'd2;

   // Monitor states.
   localparam logic [1:0] ST_DISABLED = 2'd0;
   localparam logic [1:0] ST_MONITOR  = 2'd1;
   localparam logic [1:0] ST_MEASURE  = 2'd2;

   // Charge results.
   localparam logic [1:0] RES_NONE         = 2'd0;
   localparam logic [1:0] RES_CHARGING     = 2'd1;
   localparam logic [1:0] RES_NOT_CHARGING = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_MONITOR_PERIOD = 2'd0;
   localparam logic [1:0] REG_MEASURE_PERIOD = 2'd1;
   localparam logic [1:0] REG_SETTLE_SAMPLES = 2'd2;

   // Configuration reset values.
   localparam logic [15:0] MONITOR_PERIOD_RESET = 16'd20;
   localparam logic [15:0] MEASURE_PERIOD_RESET = 16'd1;
   localparam logic [7:0]  SETTLE_SAMPLES_RESET = 8'd200;

   // Saturation limit of the 8-bit counters.
   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] elapsed_ticks;
      logic        chg_line;
      logic        vbus_present;
   } req_type;

   typedef struct packed {
      logic [1:0] monitor_state;
      logic [1:0] charge_result;
      logic       status_report;
      logic [7:0] line_changes;
   } rsp_type;

   typedef struct packed {
      logic [15:0] monitor_period;
      logic [15:0] measure_period;
      logic [7:0]  settle_samples;
   } cfg_type;

endpackage

>>> src/clm_csr.sv
// Configuration registers of the charge line monitor.
// Depends on clm_pkg for the register indexes, reset values and cfg_type.
module clm_csr
   import clm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an index past the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MONITOR_PERIOD: cfg_in.monitor_period = csr_wdata;
            REG_MEASURE_PERIOD: cfg_in.measure_period = csr_wdata;
            REG_SETTLE_SAMPLES: cfg_in.settle_samples = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.monitor_period <= MONITOR_PERIOD_RESET;
         cfg_ff.measure_period <= MEASURE_PERIOD_RESET;
         cfg_ff.settle_samples <= SETTLE_SAMPLES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/clm_core.sv
// State machine, timer and change counting of the charge line monitor.
// Depends on clm_pkg and on charge_line_monitor_defines.svh for assertions.
`include "charge_line_monitor_defines.svh"

module clm_core
   import clm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [1:0]  state_ff,   state_in;
   logic [15:0] timer_ff,   timer_in;
   logic        tmr_en_ff,  tmr_en_in;
   logic        line_ff,    line_in;
   logic        known_ff,   known_in;
   logic [1:0]  result_ff,  result_in;
   logic [7:0]  loops_ff,   loops_in;
   logic [7:0]  count_ff,   count_in;
   logic        report;

   // Next state for one request.
   always_comb begin
      logic       changed;
      logic       fire;
      logic [1:0] res;
      logic [1:0] st_a;
      logic [7:0] loops_b;

      changed = !known_ff || (req.chg_line != line_ff);
      res     = req.chg_line ? RES_NOT_CHARGING : RES_CHARGING;
      fire    = 1'b0;
      st_a    = state_ff;
      loops_b = loops_ff;

      state_in  = state_ff;
      timer_in  = timer_ff;
      tmr_en_in = tmr_en_ff;
      line_in   = line_ff;
      known_in  = known_ff;
      result_in = result_ff;
      loops_in  = loops_ff;
      count_in  = count_ff;
      report    = 1'b0;

      case (req.cmd)
         CMD_ENABLE: begin
            state_in  = ST_MONITOR;
            timer_in  = cfg.monitor_period;
            tmr_en_in = 1'b1;
            loops_in  = '0;
            count_in  = '0;
         end
         CMD_DISABLE: begin
            state_in  = ST_DISABLED;
            timer_in  = '0;
            tmr_en_in = 1'b0;
            line_in   = 1'b0;
            known_in  = 1'b0;
            result_in = RES_NONE;
            loops_in  = '0;
            count_in  = '0;
         end
         CMD_TICK: begin
            if (state_ff != ST_DISABLED && tmr_en_ff) begin
               if (req.elapsed_ticks >= timer_ff) begin
                  // Timer expired: sample the line.
                  if (changed) begin
                     line_in  = req.chg_line;
                     known_in = 1'b1;
                     if (state_ff == ST_MONITOR) begin
                        st_a     = ST_MEASURE;
                        loops_in = '0;
                        count_in = '0;
                        fire     = 1'b1;
                     end else if (count_ff < COUNT_MAX) begin
                        count_in = count_ff + 8'd1;
                     end
                  end
                  state_in = st_a;
                  // Count samples in measure and return to monitor when settled.
                  if (st_a == ST_MEASURE) begin
                     loops_b  = (loops_in < COUNT_MAX) ? loops_in + 8'd1 : loops_in;
                     loops_in = loops_b;
                     if (loops_b >= cfg.settle_samples) begin
                        state_in = ST_MONITOR;
                        loops_in = '0;
                        count_in = '0;
                        fire     = 1'b1;
                     end
                  end
                  timer_in  = (state_in == ST_MEASURE) ? cfg.measure_period
                                                       : cfg.monitor_period;
                  tmr_en_in = 1'b1;
                  // A second firing in the same request posts the same result and raises no extra report.
                  if (fire) begin
                     result_in = res;
                     report    = (result_ff != res) && req.vbus_present;
                  end
               end else begin
                  timer_in = timer_ff - req.elapsed_ticks;
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // State registers advance only when a request moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_DISABLED;
         timer_ff  <= '0;
         tmr_en_ff <= 1'b0;
         line_ff   <= 1'b0;
         known_ff  <= 1'b0;
         result_ff <= RES_NONE;
         loops_ff  <= '0;
         count_ff  <= '0;
      end else if (step) begin
         state_ff  <= state_in;
         timer_ff  <= timer_in;
         tmr_en_ff <= tmr_en_in;
         line_ff   <= line_in;
         known_ff  <= known_in;
         result_ff <= result_in;
         loops_ff  <= loops_in;
         count_ff  <= count_in;
      end
   end

   // Result of this request, taken after its update.
   always_comb begin
      rsp.monitor_state = state_in;
      rsp.charge_result = result_in;
      rsp.status_report = report;
      rsp.line_changes  = count_in;
   end

   // Counters only run while measuring.
   `CLM_ASSERT_IMP(a_count_in_measure, clock, reset, count_ff != 8'd0, state_ff == ST_MEASURE)
   `CLM_ASSERT_IMP(a_loops_in_measure, clock, reset, loops_ff != 8'd0, state_ff == ST_MEASURE)
   // An active state always has a running timer.
   `CLM_ASSERT_IMP(a_timer_running, clock, reset, state_ff != ST_DISABLED, tmr_en_ff)
   // A report needs external power.
   `CLM_ASSERT_IMP(a_report_vbus, clock, reset, report, req.vbus_present)
   // A disable request clears the state machine.
   `CLM_ASSERT_NXT(a_disable_clears, clock, reset, step && req.cmd == CMD_DISABLE,
                   state_ff == ST_DISABLED && result_ff == RES_NONE)

endmodule

>>> src/charge_line_monitor.sv
// Top level of the charge line monitor: request register, core and result register.
// Depends on clm_pkg, clm_csr and clm_core.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_payload (req_type)
//   rsp       out        rsp_valid/rsp_stall   rsp_payload (rsp_type)
//   csr       in         csr_we                csr_index, csr_wdata
//
// Each request's response is offered on rsp_valid after it has passed the request
// register and the result register; one request per cycle is sustained while the
// response is not stalled, as the core updates its state for each advancing request.
// Reset is synchronous and clears the state machine and configuration registers.
// A stalled response holds in the result register; the request register then
// holds one more request and req_stall rises until the response is taken.
module charge_line_monitor
   import clm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type core_rsp;

   // A request moves on when the result register is empty or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   clm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   clm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

>>> sim/tb_charge_line_monitor.sv
`timescale 1ns / 1ps
// Self-checking testbench for charge_line_monitor: a table of directed requests, then
// random phases under several register settings, responses checked against table or predictor.
// Depends on clm_pkg and the charge_line_monitor RTL.
module tb_charge_line_monitor;
   import clm_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 5;

   localparam rsp_type RSP_OFF   = '{ST_DISABLED, RES_NONE, 1'b0, 8'd0};
   localparam rsp_type RSP_ARMED = '{ST_MONITOR, RES_NONE, 1'b0, 8'd0};

   // One directed request; exp is only compared when known is set.
   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type exp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_MONITOR_PERIOD;
   logic [15:0] csr_wdata = '0;

   // Typed expectation travelling alongside the request on offer.
   logic    req_has_exp = 1'b0;
   rsp_type req_exp = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   rsp_type expected_status_q [$];

   // Predictor copy of the configuration and state.
   logic [15:0] cfg_monitor_period = MONITOR_PERIOD_RESET;
   logic [15:0] cfg_measure_period = MEASURE_PERIOD_RESET;
   logic [7:0]  cfg_settle_samples = SETTLE_SAMPLES_RESET;
   logic [1:0]  mon_state;
   logic [15:0] timer_left;
   logic        timer_armed;
   logic        line_seen;
   logic        line_valid;
   logic [1:0]  result_held;
   logic [7:0]  loops_done;
   logic [7:0]  change_total;

   // Random generator's view of the line and of whether the block is off.
   logic gen_line = 1'b0;
   logic gen_off = 1'b1;

   dir_row_type directed [17] = '{
      '{'{CMD_TICK,    16'hFFFF, 1'b1, 1'b1}, 1'b1, RSP_OFF},
      '{'{CMD_UNUSED,  16'h0000, 1'b0, 1'b1}, 1'b1, RSP_OFF},
      '{'{CMD_ENABLE,  16'h0000, 1'b0, 1'b1}, 1'b1, RSP_ARMED},
      '{'{CMD_TICK,    16'd0,    1'b0, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'd19,   1'b0, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'd1,    1'b0, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'hFFFF, 1'b1, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'd1,    1'b0, 1'b0}, 1'b0, RSP_OFF},
      '{'{CMD_UNUSED,  16'h0000, 1'b1, 1'b0}, 1'b0, RSP_OFF},
      '{'{CMD_DISABLE, 16'hFFFF, 1'b1, 1'b1}, 1'b1, RSP_OFF},
      '{'{CMD_ENABLE,  16'h0000, 1'b0, 1'b0}, 1'b1, RSP_ARMED},
      '{'{CMD_TICK,    16'hFFFF, 1'b1, 1'b0}, 1'b0, RSP_OFF},
      '{'{CMD_ENABLE,  16'h0000, 1'b1, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'hFFFF, 1'b1, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_TICK,    16'd20,   1'b0, 1'b1}, 1'b0, RSP_OFF},
      '{'{CMD_DISABLE, 16'h0000, 1'b0, 1'b0}, 1'b1, RSP_OFF},
      '{'{CMD_TICK,    16'd0,    1'b0, 1'b0}, 1'b1, RSP_OFF}
   };

   charge_line_monitor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Back to the power-on state; the registers are not touched.
   function automatic void clear_monitor();
      mon_state    = ST_DISABLED;
      timer_left   = '0;
      timer_armed  = 1'b0;
      line_seen    = 1'b0;
      line_valid   = 1'b0;
      result_held  = RES_NONE;
      loops_done   = '0;
      change_total = '0;
   endfunction

   function automatic logic [15:0] reload_for(logic [1:0] s);
      return (s == ST_MEASURE) ? cfg_measure_period : cfg_monitor_period;
   endfunction

   function automatic void enter_state(logic [1:0] nxt);
      change_total = '0;
      loops_done   = '0;
      mon_state    = nxt;
      timer_left   = reload_for(nxt);
      timer_armed  = 1'b1;
   endfunction

   // A result only counts as reported when it is new and external power is up.
   function automatic logic post_result(logic [1:0] res, logic vbus);
      if (result_held == res)
         return 1'b0;
      result_held = res;
      return vbus;
   endfunction

   function automatic rsp_type predict_charge_status(req_type r);
      rsp_type    o;
      logic       rep;
      logic [1:0] res;
      rep = 1'b0;
      res = r.chg_line ? RES_NOT_CHARGING : RES_CHARGING;
      case (r.cmd)
         CMD_ENABLE: enter_state(ST_MONITOR);
         CMD_DISABLE: clear_monitor();
         CMD_TICK: begin
            if (mon_state != ST_DISABLED && timer_armed) begin
               if (r.elapsed_ticks >= timer_left) begin
                  // Expiry: an unknown last line always counts as a change.
                  if (!line_valid || r.chg_line != line_seen) begin
                     line_seen  = r.chg_line;
                     line_valid = 1'b1;
                     if (mon_state == ST_MONITOR) begin
                        enter_state(ST_MEASURE);
                        rep |= post_result(res, r.vbus_present);
                     end else if (change_total < COUNT_MAX) begin
                        change_total++;
                     end
                  end
                  if (mon_state == ST_MEASURE) begin
                     if (loops_done < COUNT_MAX)
                        loops_done++;
                     if (loops_done >= cfg_settle_samples) begin
                        enter_state(ST_MONITOR);
                        rep |= post_result(res, r.vbus_present);
                     end
                  end
                  timer_left  = reload_for(mon_state);
                  timer_armed = 1'b1;
               end else begin
                  timer_left = timer_left - r.elapsed_ticks;
               end
            end
         end
         default: ;
      endcase
      o.monitor_state = mon_state;
      o.charge_result = result_held;
      o.status_report = rep;
      o.line_changes  = change_total;
      return o;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Mostly ticks, most of them short or within twice the longer timer period, with an often toggling line.
   function automatic req_type next_random_request();
      req_type r;
      int      roll;
      int      span;
      roll = $urandom_range(99);
      span = int'((cfg_monitor_period > cfg_measure_period) ? cfg_monitor_period
                                                            : cfg_measure_period);
      span = 2 * span + 1;
      if (span > 65535)
         span = 65535;
      if (gen_off && roll < 80)
         r.cmd = CMD_ENABLE;
      else if (roll < 3)
         r.cmd = CMD_DISABLE;
      else if (roll < 7)
         r.cmd = CMD_ENABLE;
      else
         r.cmd = CMD_TICK;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: r.elapsed_ticks = 16'($urandom_range(3));
         5, 6: r.elapsed_ticks = 16'($urandom_range(span));
         7, 8: r.elapsed_ticks = 16'($urandom_range(65535));
         default: r.elapsed_ticks = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      if ($urandom_range(99) < 40)
         gen_line = ~gen_line;
      r.chg_line = gen_line;
      r.vbus_present = ($urandom_range(99) < 85);
      if (r.cmd == CMD_DISABLE)
         gen_off = 1'b1;
      else if (r.cmd == CMD_ENABLE)
         gen_off = 1'b0;
      return r;
   endfunction

   // Offer one request and return at the edge where it is taken.
   task automatic offer_request(input req_type r, input logic known, input rsp_type exp);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      req_has_exp <= known;
      req_exp     <= exp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Wait until every response is back and the pipeline has settled.
   task automatic finish_outstanding();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_MONITOR_PERIOD: cfg_monitor_period = val;
         REG_MEASURE_PERIOD: cfg_measure_period = val;
         REG_SETTLE_SAMPLES: cfg_settle_samples = val[7:0];
         default: ;
      endcase
   endtask

   // One random phase: new register settings, idling and stall mixes, an enable, then random requests.
   task automatic run_phase(input logic [15:0] mon_period, input logic [15:0] meas_period,
                            input logic [15:0] settle_word, input int send_pct,
                            input int stall_pct, input int count, input logic hold);
      req_type r;
      finish_outstanding();
      write_reg(REG_MONITOR_PERIOD, mon_period);
      write_reg(REG_MEASURE_PERIOD, meas_period);
      write_reg(REG_SETTLE_SAMPLES, settle_word);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      r = '{CMD_ENABLE, 16'h0000, gen_line, 1'b1};
      gen_off = 1'b0;
      offer_request(r, 1'b0, RSP_OFF);
      for (int i = 0; i < count; i++) begin
         if (hold && i == count / 3)
            hold_req <= hold_req + 1;
         offer_request(next_random_request(), 1'b0, RSP_OFF);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Predict on each accepted request, then check each accepted response in order.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_charge_status(req_payload);
            expected_status_q.push_back(req_has_exp ? req_exp : want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("monitor_state", 32'(want.monitor_state),
                           32'(rsp_payload.monitor_state));
               check_field("charge_result", 32'(want.charge_result),
                           32'(rsp_payload.charge_result));
               check_field("status_report", 32'(want.status_report),
                           32'(rsp_payload.status_report));
               check_field("line_changes", 32'(want.line_changes),
                           32'(rsp_payload.line_changes));
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      clear_monitor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset register values.
      for (int k = 0; k < $size(directed); k++)
         offer_request(directed[k].req, directed[k].known, directed[k].exp);
      gen_off = 1'b1;

      // Random phases; the long receiver hold-off comes in the first one.
      run_phase(16'd3, 16'd1, 16'd4, 0, 0, 130, 1'b1);
      run_phase(16'd1, 16'd1, 16'd1, 58, 0, 120, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'd255, 0, 58, 100, 1'b0);
      run_phase(16'd0, 16'd0, 16'd0, 17, 17, 100, 1'b0);
      run_phase(16'd2, 16'd1, 16'hA5FF, 0, 0, 280, 1'b0);
      run_phase(16'($urandom_range(8, 1)), 16'($urandom_range(4, 1)),
                16'($urandom_range(16, 1)), 58, 0, 130, 1'b0);
      run_phase(16'($urandom_range(8, 1)), 16'($urandom_range(4, 1)),
                16'($urandom_range(16, 1)), 0, 58, 130, 1'b0);
      run_phase(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                16'($urandom_range(65535, 0)), 17, 17, 100, 1'b0);

      finish_outstanding();
      if (mismatches == 0 && expected_status_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
